>>> rtl/core/ltc_pkg.sv
`timescale 1ns / 1ps

package ltc_pkg;

  localparam int ENTRIES   = 24;
  localparam int KEY_W     = 8;
  localparam int STAMP_W   = 8;
  localparam int SLOT_W    = 5;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int LEAVES    = 1 << IDX_W;

  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [KEY_W-1:0] TAG_RESET = 8'hFF;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [QPTR_W-1:0]  qptr_t;
  typedef logic [QCNT_W-1:0]  qcnt_t;

  typedef struct packed {
    logic  hit;
    slot_t slot;
  } res_t;

endpackage

>>> rtl/core/lru_tag_cache_lookup.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// --------  ---------  --------------------  -----------------
// lookup    in         push_i / full_o       key_i (8 bits)
// result    out        pop_i / empty_o       hit_o, slot_o (1 + 5 bits)
//
// Each lookup goes through the engine's match state, which compares the key
// against all tags and picks the oldest stamp, then its commit state, which
// writes the stamp, the use clock and, on a miss, the tag, and pushes the
// result. The engine takes a new key only after it has committed the last one.
// Reset is asynchronous and active low; it fills all tags with 0xFF and clears
// stamps and the use clock at once, so the block is ready on its release.
// A full result queue stalls the engine in its commit cycle; two keys are
// buffered in front, so lookups keep arriving while the engine waits.

module lru_tag_cache_lookup (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] key_i,
  input  logic       pop_i,
  output logic       empty_o,
  output logic       hit_o,
  output logic [4:0] slot_o
);

  logic          key_valid;
  ltc_pkg::key_t key_head;
  logic          key_pop;
  logic          res_full;
  logic          res_push;
  ltc_pkg::res_t res_in;
  ltc_pkg::res_t res_head;

  ltc_key_queue u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .key_i   (key_i),
    .full_o  (full_o),
    .valid_o (key_valid),
    .key_o   (key_head),
    .pop_i   (key_pop)
  );

  ltc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_valid_i (key_valid),
    .key_i       (key_head),
    .key_pop_o   (key_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  ltc_result_queue u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_in),
    .full_o  (res_full),
    .empty_o (empty_o),
    .res_o   (res_head),
    .pop_i   (pop_i)
  );

  assign hit_o  = res_head.hit;
  assign slot_o = res_head.slot;

endmodule

>>> rtl/core/ltc_key_queue.sv
`timescale 1ns / 1ps

module ltc_key_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ltc_pkg::key_t key_i,
  output logic          full_o,
  output logic          valid_o,
  output ltc_pkg::key_t key_o,
  input  logic          pop_i
);

  ltc_pkg::key_t  mem_q [ltc_pkg::QDEPTH];
  ltc_pkg::qptr_t wr_q, wr_d;
  ltc_pkg::qptr_t rd_q, rd_d;
  ltc_pkg::qcnt_t cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == ltc_pkg::qcnt_t'(ltc_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign key_o   = mem_q[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == ltc_pkg::qptr_t'(ltc_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == ltc_pkg::qptr_t'(ltc_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= key_i;
    end
  end

endmodule

>>> rtl/core/ltc_result_queue.sv
`timescale 1ns / 1ps

module ltc_result_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ltc_pkg::res_t res_i,
  output logic          full_o,
  output logic          empty_o,
  output ltc_pkg::res_t res_o,
  input  logic          pop_i
);

  ltc_pkg::res_t  mem_q [ltc_pkg::QDEPTH];
  ltc_pkg::qptr_t wr_q, wr_d;
  ltc_pkg::qptr_t rd_q, rd_d;
  ltc_pkg::qcnt_t cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == ltc_pkg::qcnt_t'(ltc_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign res_o   = mem_q[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == ltc_pkg::qptr_t'(ltc_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == ltc_pkg::qptr_t'(ltc_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= res_i;
    end
  end

endmodule

>>> rtl/core/ltc_engine.sv
`timescale 1ns / 1ps

module ltc_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          key_valid_i,
  input  ltc_pkg::key_t key_i,
  output logic          key_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output ltc_pkg::res_t res_o
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_UPD
  } state_e;

  state_e           state_q;
  ltc_pkg::key_t    key_q;
  logic             hit_q;
  ltc_pkg::idx_t    pick_q;
  ltc_pkg::key_t    tag_q   [ltc_pkg::ENTRIES];
  ltc_pkg::stamp_t  stamp_q [ltc_pkg::ENTRIES];
  ltc_pkg::stamp_t  clock_q, clock_d;

  logic             match_hit;
  ltc_pkg::idx_t    match_idx;
  ltc_pkg::idx_t    victim_idx;

  logic             nd_pad [2*ltc_pkg::LEAVES];
  ltc_pkg::stamp_t  nd_st  [2*ltc_pkg::LEAVES];
  ltc_pkg::idx_t    nd_ix  [2*ltc_pkg::LEAVES];

  // Lowest matching slot wins: scan from the top so lower slots overwrite.
  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    for (int i = ltc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (tag_q[i] == key_i) begin
        match_hit = 1'b1;
        match_idx = ltc_pkg::idx_t'(i);
      end
    end
  end

  // Argmin tree over the stamps; padding leaves always lose, ties go left.
  always_comb begin
    for (int i = 0; i < 2*ltc_pkg::LEAVES; i++) begin
      nd_pad[i] = 1'b1;
      nd_st[i]  = '1;
      nd_ix[i]  = '0;
    end
    for (int i = 0; i < ltc_pkg::ENTRIES; i++) begin
      nd_pad[ltc_pkg::LEAVES + i] = 1'b0;
      nd_st[ltc_pkg::LEAVES + i]  = stamp_q[i];
      nd_ix[ltc_pkg::LEAVES + i]  = ltc_pkg::idx_t'(i);
    end
    for (int n = ltc_pkg::LEAVES - 1; n >= 1; n--) begin
      if ({nd_pad[2*n], nd_st[2*n]} <= {nd_pad[2*n+1], nd_st[2*n+1]}) begin
        nd_pad[n] = nd_pad[2*n];
        nd_st[n]  = nd_st[2*n];
        nd_ix[n]  = nd_ix[2*n];
      end else begin
        nd_pad[n] = nd_pad[2*n+1];
        nd_st[n]  = nd_st[2*n+1];
        nd_ix[n]  = nd_ix[2*n+1];
      end
    end
    victim_idx = nd_ix[1];
  end

  assign clock_d    = clock_q + 1'b1;
  assign key_pop_o  = (state_q == S_IDLE) && key_valid_i;
  assign res_push_o = (state_q == S_UPD) && !res_full_i;
  assign res_o.hit  = hit_q;
  assign res_o.slot = ltc_pkg::slot_t'(pick_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      key_q   <= '0;
      hit_q   <= 1'b0;
      pick_q  <= '0;
      clock_q <= '0;
      for (int i = 0; i < ltc_pkg::ENTRIES; i++) begin
        tag_q[i]   <= ltc_pkg::TAG_RESET;
        stamp_q[i] <= '0;
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (key_pop_o) begin
            key_q   <= key_i;
            hit_q   <= match_hit;
            pick_q  <= match_hit ? match_idx : victim_idx;
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          // hold until the result queue has room, then commit
          if (res_push_o) begin
            clock_q         <= clock_d;
            stamp_q[pick_q] <= clock_d;
            if (!hit_q) begin
              tag_q[pick_q] <= key_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_pop_enters_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_pop_o |=> (state_q == S_UPD))
    else $error("key transfer did not start an update");

  a_clock_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> (clock_q == ltc_pkg::stamp_t'($past(clock_q) + 1'b1)))
    else $error("use clock did not advance on result transfer");

  a_hit_tag_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) && hit_q |-> (tag_q[pick_q] == key_q))
    else $error("hit slot tag differs from key");

  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (int'(pick_q) < ltc_pkg::ENTRIES))
    else $error("picked slot out of range");

  a_commit_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> (stamp_q[$past(pick_q)] == clock_q))
    else $error("picked slot did not take the new clock");
`endif

endmodule
